FILE: design/lcms_pkg.sv
package lcms_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_START_STOP = 2'd0,
    CMD_FOLLOWER   = 2'd1,
    CMD_ULTRASONIC = 2'd2,
    CMD_DISTANCE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LEFT_SWERVE  = 3'd0,
    REG_RIGHT_SWERVE = 3'd1,
    REG_RIGHT_BACK   = 3'd2,
    REG_LEFT_BACK    = 3'd3,
    REG_CHANGE_SPEED = 3'd4,
    REG_OVERTAKE_SPD = 3'd5,
    REG_LEFT_STEER   = 3'd6,
    REG_RIGHT_STEER  = 3'd7
  } reg_idx_t;

  typedef enum logic [8:0] {
    MODE_IDLE       = 9'b0_0000_0001,
    MODE_LEFT       = 9'b0_0000_0010,
    MODE_RIGHT      = 9'b0_0000_0100,
    MODE_CHK_FR     = 9'b0_0000_1000,
    MODE_CHK_R      = 9'b0_0001_0000,
    MODE_CHK_RR     = 9'b0_0010_0000,
    MODE_BACK_RIGHT = 9'b0_0100_0000,
    MODE_BACK_LEFT  = 9'b0_1000_0000,
    MODE_FINISH     = 9'b1_0000_0000
  } mode_t;

  // Passing checks
  localparam logic [9:0]  FREE_RANGE_CM  = 10'd100;
  localparam logic [9:0]  RANGE_RESET_CM = 10'd400;
  localparam logic [15:0] CHK_FR_DIST_MM = 16'd200;
  localparam logic [15:0] CHK_R_DIST_MM  = 16'd300;
  localparam logic [15:0] CHK_RR_DIST_MM = 16'd200;

  // Register reset values
  localparam logic [15:0] LEFT_SWERVE_RST  = 16'd700;
  localparam logic [15:0] RIGHT_SWERVE_RST = 16'd600;
  localparam logic [15:0] RIGHT_BACK_RST   = 16'd600;
  localparam logic [15:0] LEFT_BACK_RST    = 16'd700;
  localparam logic [15:0] CHANGE_SPEED_RST = 16'd350;
  localparam logic [15:0] OVERTAKE_SPD_RST = 16'd400;
  localparam logic [14:0] LEFT_STEER_RST   = 15'd9000;
  localparam logic [14:0] RIGHT_STEER_RST  = 15'd9000;

  typedef struct packed {
    logic        [15:0] left_swerve_dist_mm;
    logic        [15:0] right_swerve_dist_mm;
    logic        [15:0] right_back_dist_mm;
    logic        [15:0] left_back_dist_mm;
    logic signed [15:0] change_speed;
    logic signed [15:0] overtake_speed;
    logic        [14:0] left_steer;
    logic        [14:0] right_steer;
  } cfg_t;

  typedef struct packed {
    cmd_t               command;
    logic               start_request;
    logic signed [15:0] follower_steering;
    logic        [9:0]  front_right_cm;
    logic        [9:0]  side_right_cm;
    logic        [31:0] distance_mm;
  } evt_t;

  typedef struct packed {
    logic signed [15:0] steering_out;
    logic signed [15:0] speed_out;
    logic               left_indicator;
    logic               finished;
  } res_t;

endpackage

FILE: design/lcms_chan_if.sv
interface lcms_evt_if import lcms_pkg::*;;
  logic               valid;
  logic               ready;
  cmd_t               command;
  logic               start_request;
  logic signed [15:0] follower_steering;
  logic        [9:0]  front_right_cm;
  logic        [9:0]  side_right_cm;
  logic        [31:0] distance_mm;

  modport source (
    output valid, command, start_request, follower_steering,
    output front_right_cm, side_right_cm, distance_mm,
    input  ready
  );
  modport sink (
    input  valid, command, start_request, follower_steering,
    input  front_right_cm, side_right_cm, distance_mm,
    output ready
  );
endinterface

interface lcms_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steering_out;
  logic signed [15:0] speed_out;
  logic               left_indicator;
  logic               finished;

  modport source (
    output valid, steering_out, speed_out, left_indicator, finished,
    input  ready
  );
  modport sink (
    input  valid, steering_out, speed_out, left_indicator, finished,
    output ready
  );
endinterface

FILE: design/lcms_cfg_regs.sv
module lcms_cfg_regs import lcms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_swerve_dist_mm  <= LEFT_SWERVE_RST;
      cfg.right_swerve_dist_mm <= RIGHT_SWERVE_RST;
      cfg.right_back_dist_mm   <= RIGHT_BACK_RST;
      cfg.left_back_dist_mm    <= LEFT_BACK_RST;
      cfg.change_speed         <= CHANGE_SPEED_RST;
      cfg.overtake_speed       <= OVERTAKE_SPD_RST;
      cfg.left_steer           <= LEFT_STEER_RST;
      cfg.right_steer          <= RIGHT_STEER_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LEFT_SWERVE:  cfg.left_swerve_dist_mm  <= pwdata[15:0];
        REG_RIGHT_SWERVE: cfg.right_swerve_dist_mm <= pwdata[15:0];
        REG_RIGHT_BACK:   cfg.right_back_dist_mm   <= pwdata[15:0];
        REG_LEFT_BACK:    cfg.left_back_dist_mm    <= pwdata[15:0];
        REG_CHANGE_SPEED: cfg.change_speed         <= pwdata[15:0];
        REG_OVERTAKE_SPD: cfg.overtake_speed       <= pwdata[15:0];
        REG_LEFT_STEER:   cfg.left_steer           <= pwdata[14:0];
        REG_RIGHT_STEER:  cfg.right_steer          <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Zero-extend every register on read
  always_comb begin
    case (idx)
      REG_LEFT_SWERVE:  prdata = {16'd0, cfg.left_swerve_dist_mm};
      REG_RIGHT_SWERVE: prdata = {16'd0, cfg.right_swerve_dist_mm};
      REG_RIGHT_BACK:   prdata = {16'd0, cfg.right_back_dist_mm};
      REG_LEFT_BACK:    prdata = {16'd0, cfg.left_back_dist_mm};
      REG_CHANGE_SPEED: prdata = {16'd0, cfg.change_speed};
      REG_OVERTAKE_SPD: prdata = {16'd0, cfg.overtake_speed};
      REG_LEFT_STEER:   prdata = {17'd0, cfg.left_steer};
      REG_RIGHT_STEER:  prdata = {17'd0, cfg.right_steer};
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: design/lcms_seq_core.sv
module lcms_seq_core import lcms_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  evt_t item,
  input  cfg_t cfg,
  output logic emits,
  output res_t res
);

  mode_t              mode, mode_next;
  logic               armed, armed_next;
  logic [31:0]        mode_start, mode_start_next;
  logic [9:0]         fr_range, fr_range_next;
  logic [9:0]         sr_range, sr_range_next;
  logic signed [15:0] steer_held, steer_held_next;
  logic               ind_on, ind_on_next;
  logic               finish_seen, finish_seen_next;

  logic [31:0]        delta;
  logic [15:0]        limit;
  logic               over;
  logic signed [15:0] neg_left, right_val, steer, speed;

  assign delta     = item.distance_mm - mode_start;
  assign over      = delta > {16'd0, limit};
  assign neg_left  = 16'd0 - {1'b0, cfg.left_steer};
  assign right_val = {1'b0, cfg.right_steer};

  // Threshold of the current mode
  always_comb begin
    case (mode)
      MODE_LEFT:       limit = cfg.left_swerve_dist_mm;
      MODE_RIGHT:      limit = cfg.right_swerve_dist_mm;
      MODE_CHK_FR:     limit = CHK_FR_DIST_MM;
      MODE_CHK_R:      limit = CHK_R_DIST_MM;
      MODE_CHK_RR:     limit = CHK_RR_DIST_MM;
      MODE_BACK_RIGHT: limit = cfg.right_back_dist_mm;
      MODE_BACK_LEFT:  limit = cfg.left_back_dist_mm;
      default:         limit = '0;
    endcase
  end

  always_comb begin
    mode_next        = mode;
    armed_next       = armed;
    mode_start_next  = mode_start;
    fr_range_next    = fr_range;
    sr_range_next    = sr_range;
    steer_held_next  = steer_held;
    ind_on_next      = ind_on;
    finish_seen_next = finish_seen;
    steer            = '0;
    speed            = '0;
    emits            = 1'b0;
    case (item.command)
      CMD_START_STOP: begin
        armed_next = item.start_request;
        if (!item.start_request) begin
          mode_next   = MODE_IDLE;
          ind_on_next = 1'b0;
          emits       = 1'b1;
        end
      end
      CMD_FOLLOWER: begin
        steer_held_next = item.follower_steering;
      end
      CMD_ULTRASONIC: begin
        if (item.front_right_cm != '0) fr_range_next = item.front_right_cm;
        if (item.side_right_cm != '0) sr_range_next = item.side_right_cm;
      end
      CMD_DISTANCE: begin
        if (armed) begin
          emits = 1'b1;
          case (mode)
            MODE_LEFT, MODE_BACK_LEFT: begin
              steer = neg_left;
              speed = cfg.change_speed;
              if (over) begin
                mode_next       = (mode == MODE_LEFT) ? MODE_RIGHT : MODE_FINISH;
                mode_start_next = item.distance_mm;
              end
            end
            MODE_RIGHT, MODE_BACK_RIGHT: begin
              steer = right_val;
              speed = cfg.change_speed;
              if (over) begin
                mode_next       = (mode == MODE_RIGHT) ? MODE_CHK_FR : MODE_BACK_LEFT;
                mode_start_next = item.distance_mm;
              end
            end
            MODE_CHK_FR: begin
              steer       = steer_held;
              speed       = cfg.overtake_speed;
              ind_on_next = 1'b0;
              if (fr_range > FREE_RANGE_CM && over) begin
                mode_next       = MODE_CHK_R;
                mode_start_next = item.distance_mm;
              end
            end
            MODE_CHK_R: begin
              steer = steer_held;
              speed = cfg.overtake_speed;
              if (sr_range > FREE_RANGE_CM && over) begin
                mode_next       = MODE_CHK_RR;
                mode_start_next = item.distance_mm;
              end
            end
            MODE_CHK_RR: begin
              steer = steer_held;
              speed = cfg.overtake_speed;
              if (over) begin
                mode_next       = MODE_BACK_RIGHT;
                mode_start_next = item.distance_mm;
              end else if (sr_range < FREE_RANGE_CM) begin
                // restart the rear check while something is still beside us
                mode_start_next = item.distance_mm;
              end
            end
            MODE_FINISH: begin
              finish_seen_next = 1'b1;
              armed_next       = 1'b0;
              mode_next        = MODE_IDLE;
              ind_on_next      = 1'b0;
            end
            default: begin
              mode_next       = MODE_LEFT;
              mode_start_next = item.distance_mm;
              ind_on_next     = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign res.steering_out   = steer;
  assign res.speed_out      = speed;
  assign res.left_indicator = ind_on_next;
  assign res.finished       = finish_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      armed       <= 1'b0;
      mode_start  <= '0;
      fr_range    <= RANGE_RESET_CM;
      sr_range    <= RANGE_RESET_CM;
      steer_held  <= '0;
      ind_on      <= 1'b0;
      finish_seen <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      armed       <= armed_next;
      mode_start  <= mode_start_next;
      fr_range    <= fr_range_next;
      sr_range    <= sr_range_next;
      steer_held  <= steer_held_next;
      ind_on      <= ind_on_next;
      finish_seen <= finish_seen_next;
    end
  end

endmodule

FILE: design/lane_change_maneuver_sequencer.sv
// Channel    Role    Handshake      Payload
// event_ch   sink    valid/ready    command, start_request, follower_steering,
//                                   front_right_cm, side_right_cm, distance_mm
// result_ch  source  valid/ready    steering_out, speed_out, left_indicator,
//                                   finished
// APB        slave   psel/penable   8 registers at 4*i, pready tied high
//
// One event per cycle sustained while no held result stalls it; an emitting
// event's result passes the input register, then the result register.
// The sequencer state updates in one pass of compare-and-select logic.
// Reset (rst, synchronous) empties both registers and returns all state and
// configuration to defaults.
// A held result stalls only events that emit; others keep flowing past it.
module lane_change_maneuver_sequencer import lcms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lcms_evt_if.sink              event_ch,
  lcms_res_if.source            result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  // Input register
  logic s1_valid;
  evt_t s1_item;
  logic s1_go;
  logic in_xfer;

  // Result register
  logic out_valid;
  res_t out_res;

  logic emits;
  res_t res;

  lcms_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcms_seq_core u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (s1_go),
    .item  (s1_item),
    .cfg   (cfg),
    .emits (emits),
    .res   (res)
  );

  // Advance the held event unless it emits into a full, stalled result register
  assign s1_go          = s1_valid && (!emits || !out_valid || result_ch.ready);
  assign event_ch.ready = !s1_valid || s1_go;
  assign in_xfer        = event_ch.valid && event_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item.command           <= event_ch.command;
      s1_item.start_request     <= event_ch.start_request;
      s1_item.follower_steering <= event_ch.follower_steering;
      s1_item.front_right_cm    <= event_ch.front_right_cm;
      s1_item.side_right_cm     <= event_ch.side_right_cm;
      s1_item.distance_mm       <= event_ch.distance_mm;
    end
  end

  // Load a result when an emitting event advances; drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emits) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emits) begin
      out_res <= res;
    end
  end

  assign result_ch.valid          = out_valid;
  assign result_ch.steering_out   = out_res.steering_out;
  assign result_ch.speed_out      = out_res.speed_out;
  assign result_ch.left_indicator = out_res.left_indicator;
  assign result_ch.finished       = out_res.finished;

endmodule

FILE: design/lcms_checker.sv
module lcms_checker (
  input logic        clk,
  input logic        rst,
  input logic        evt_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_steering,
  input logic [15:0] res_speed,
  input logic        res_finished,
  input logic        pready
);

  // The result register comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Events are refused only behind a stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || res_ready) |-> evt_ready)
    else $error("event refused while result side is free");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(res_valid && !res_ready) && !$past(rst) |->
      res_valid && $stable(res_steering) && $stable(res_speed))
    else $error("stalled result changed");

  // Finish flag is sticky across results
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && $past(res_valid) && $past(res_finished) && !$past(rst) |-> res_finished)
    else $error("finished flag dropped");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind lane_change_maneuver_sequencer lcms_checker u_lcms_checker (
  .clk          (clk),
  .rst          (rst),
  .evt_ready    (event_ch.ready),
  .res_valid    (result_ch.valid),
  .res_ready    (result_ch.ready),
  .res_steering (result_ch.steering_out),
  .res_speed    (result_ch.speed_out),
  .res_finished (result_ch.finished),
  .pready       (pready)
);

FILE: bench/testbench.sv
module testbench;
  import lcms_pkg::*;

  // Scoreboard: holds its own copy of the sequencer state and settings, works
  // out the result (if any) of every accepted event, and checks results in
  // order against that prediction.
  class maneuver_scoreboard;
    cfg_t        cfg;
    mode_t       mode;
    bit          armed;
    logic [31:0] mode_start;
    logic [9:0]  front_range;
    logic [9:0]  side_range;
    logic [15:0] follower_held;
    bit          indicator_on;
    bit          finish_seen;
    res_t        expected_results[$];
    int unsigned errors;

    function new();
      cfg.left_swerve_dist_mm  = LEFT_SWERVE_RST;
      cfg.right_swerve_dist_mm = RIGHT_SWERVE_RST;
      cfg.right_back_dist_mm   = RIGHT_BACK_RST;
      cfg.left_back_dist_mm    = LEFT_BACK_RST;
      cfg.change_speed         = CHANGE_SPEED_RST;
      cfg.overtake_speed       = OVERTAKE_SPD_RST;
      cfg.left_steer           = LEFT_STEER_RST;
      cfg.right_steer          = RIGHT_STEER_RST;
      mode          = MODE_IDLE;
      armed         = 1'b0;
      mode_start    = '0;
      front_range   = RANGE_RESET_CM;
      side_range    = RANGE_RESET_CM;
      follower_held = '0;
      indicator_on  = 1'b0;
      finish_seen   = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_LEFT_SWERVE:  cfg.left_swerve_dist_mm  = value[15:0];
        REG_RIGHT_SWERVE: cfg.right_swerve_dist_mm = value[15:0];
        REG_RIGHT_BACK:   cfg.right_back_dist_mm   = value[15:0];
        REG_LEFT_BACK:    cfg.left_back_dist_mm    = value[15:0];
        REG_CHANGE_SPEED: cfg.change_speed         = value[15:0];
        REG_OVERTAKE_SPD: cfg.overtake_speed       = value[15:0];
        REG_LEFT_STEER:   cfg.left_steer           = value[14:0];
        REG_RIGHT_STEER:  cfg.right_steer          = value[14:0];
        default: ;
      endcase
    endfunction

    // Leave the current mode once the wrapped distance since it began
    // exceeds the limit.
    function void advance(logic [31:0] odo_mm, logic [15:0] limit, mode_t next);
      logic [31:0] travelled;
      travelled = odo_mm - mode_start;
      if (travelled > {16'd0, limit}) begin
        mode       = next;
        mode_start = odo_mm;
      end
    endfunction

    function void note_event(evt_t e);
      logic [15:0] steer;
      logic [15:0] speed;
      logic [15:0] neg_left;
      logic [31:0] travelled;
      res_t        r;
      steer     = '0;
      speed     = '0;
      neg_left  = 16'd0 - {1'b0, cfg.left_steer};
      travelled = e.distance_mm - mode_start;
      case (e.command)
        CMD_START_STOP: begin
          armed = e.start_request;
          if (armed) return;
          mode         = MODE_IDLE;
          indicator_on = 1'b0;
        end
        CMD_FOLLOWER: begin
          follower_held = e.follower_steering;
          return;
        end
        CMD_ULTRASONIC: begin
          if (e.front_right_cm != '0) front_range = e.front_right_cm;
          if (e.side_right_cm != '0) side_range = e.side_right_cm;
          return;
        end
        CMD_DISTANCE: begin
          if (!armed) return;
          case (mode)
            MODE_LEFT: begin
              steer = neg_left;
              speed = cfg.change_speed;
              advance(e.distance_mm, cfg.left_swerve_dist_mm, MODE_RIGHT);
            end
            MODE_RIGHT: begin
              steer = {1'b0, cfg.right_steer};
              speed = cfg.change_speed;
              advance(e.distance_mm, cfg.right_swerve_dist_mm, MODE_CHK_FR);
            end
            MODE_CHK_FR: begin
              steer        = follower_held;
              speed        = cfg.overtake_speed;
              indicator_on = 1'b0;
              if (front_range > FREE_RANGE_CM)
                advance(e.distance_mm, CHK_FR_DIST_MM, MODE_CHK_R);
            end
            MODE_CHK_R: begin
              steer = follower_held;
              speed = cfg.overtake_speed;
              if (side_range > FREE_RANGE_CM)
                advance(e.distance_mm, CHK_R_DIST_MM, MODE_CHK_RR);
            end
            MODE_CHK_RR: begin
              steer = follower_held;
              speed = cfg.overtake_speed;
              if (travelled > {16'd0, CHK_RR_DIST_MM}) begin
                mode       = MODE_BACK_RIGHT;
                mode_start = e.distance_mm;
              end else if (side_range < FREE_RANGE_CM) begin
                mode_start = e.distance_mm;
              end
            end
            MODE_BACK_RIGHT: begin
              steer = {1'b0, cfg.right_steer};
              speed = cfg.change_speed;
              advance(e.distance_mm, cfg.right_back_dist_mm, MODE_BACK_LEFT);
            end
            MODE_BACK_LEFT: begin
              steer = neg_left;
              speed = cfg.change_speed;
              advance(e.distance_mm, cfg.left_back_dist_mm, MODE_FINISH);
            end
            MODE_FINISH: begin
              finish_seen  = 1'b1;
              armed        = 1'b0;
              mode         = MODE_IDLE;
              indicator_on = 1'b0;
            end
            default: begin
              mode         = MODE_LEFT;
              mode_start   = e.distance_mm;
              indicator_on = 1'b1;
            end
          endcase
        end
        default: ;
      endcase
      r.steering_out   = steer;
      r.speed_out      = speed;
      r.left_indicator = indicator_on;
      r.finished       = finish_seen;
      expected_results = {expected_results, r};
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: steer %0d speed %0d ind %0b fin %0b",
                   got.steering_out, got.speed_out, got.left_indicator,
                   got.finished);
        return;
      end
      want = expected_results.pop_front();
      if (got.steering_out !== want.steering_out || got.speed_out !== want.speed_out ||
          got.left_indicator !== want.left_indicator ||
          got.finished !== want.finished) begin
        errors++;
        if (errors <= 10)
          $display("mismatch steer/speed/ind/fin: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                   want.steering_out, want.speed_out, want.left_indicator,
                   want.finished, got.steering_out, got.speed_out,
                   got.left_indicator, got.finished);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lcms_evt_if ev();
  lcms_res_if rs();

  maneuver_scoreboard sb = new();

  // steady: no idling on either side; hold_go: start the long receiver stall
  bit          steady;
  bit          hold_go;
  bit          rx_hold;
  logic [31:0] odo;

  lane_change_maneuver_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .event_ch  (ev),
    .result_ch (rs),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the run hangs on a missing handshake or result.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // Receiver: check each result transfer at the rising edge, then pick ready
  // for the next cycle at the falling edge. Drop ready about 17% of the time,
  // never in the steady stretch, always while the long stall is on.
  initial begin
    rs.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rs.valid && rs.ready)
        sb.check_result('{steering_out: rs.steering_out, speed_out: rs.speed_out,
                          left_indicator: rs.left_indicator, finished: rs.finished});
      @(negedge clk);
      rs.ready = !(rx_hold || (!steady && $urandom_range(0, 99) < 17));
    end
  end

  // Long receiver stall, counted in its own process, so that emitting events
  // back up and the block stalls its input.
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (80) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Offer one event: maybe idle for a random gap first, then hold valid until the
  // transfer and note it. Valid stays high for a following event.
  task automatic push_event(evt_t e);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 99) < 17) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      ev.valid = 1'b0;
    end
    @(negedge clk);
    ev.valid             = 1'b1;
    ev.command           = e.command;
    ev.start_request     = e.start_request;
    ev.follower_steering = e.follower_steering;
    ev.front_right_cm    = e.front_right_cm;
    ev.side_right_cm     = e.side_right_cm;
    ev.distance_mm       = e.distance_mm;
    do @(posedge clk); while (!ev.ready);
    sb.note_event(e);
  endtask

  // Build an event with random unused fields; arg fills the field that the
  // command uses (ultrasonic packs side range above front range).
  task automatic send(cmd_t cmd, logic [31:0] arg);
    evt_t e;
    e.command           = cmd;
    e.start_request     = 1'($urandom_range(0, 1));
    e.follower_steering = 16'($urandom);
    e.front_right_cm    = 10'($urandom);
    e.side_right_cm     = 10'($urandom);
    e.distance_mm       = $urandom;
    case (cmd)
      CMD_START_STOP: e.start_request = arg[0];
      CMD_FOLLOWER:   e.follower_steering = arg[15:0];
      CMD_ULTRASONIC: begin
        e.front_right_cm = arg[9:0];
        e.side_right_cm  = arg[19:10];
      end
      default:        e.distance_mm = arg;
    endcase
    push_event(e);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_settings(cfg_t c);
    apb_write(REG_LEFT_SWERVE,  {16'd0, c.left_swerve_dist_mm});
    apb_write(REG_RIGHT_SWERVE, {16'd0, c.right_swerve_dist_mm});
    apb_write(REG_RIGHT_BACK,   {16'd0, c.right_back_dist_mm});
    apb_write(REG_LEFT_BACK,    {16'd0, c.left_back_dist_mm});
    apb_write(REG_CHANGE_SPEED, {16'd0, c.change_speed});
    apb_write(REG_OVERTAKE_SPD, {16'd0, c.overtake_speed});
    apb_write(REG_LEFT_STEER,   {17'd0, c.left_steer});
    apb_write(REG_RIGHT_STEER,  {17'd0, c.right_steer});
  endtask

  // Drop valid and wait until every predicted result has arrived.
  task automatic wait_all_results();
    @(negedge clk);
    ev.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Stop the maneuver, drain, and let a non-emitting event still in the
  // input register pass before touching registers.
  task automatic finish_phase();
    send(CMD_START_STOP, 32'd0);
    wait_all_results();
    repeat (4) @(posedge clk);
  endtask

  // Ranges bunched around the free-lane limit, some invalid zeros.
  function automatic logic [9:0] pick_range(logic [9:0] raw);
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s < 4) return 10'($urandom_range(95, 105));
    if (s == 4) return '0;
    return raw;
  endfunction

  // Random part: mostly well-formed maneuvers (start, odometer steps with
  // sensor and follower updates in between), plus stops mid-maneuver,
  // repeated starts and fully random events.
  task automatic random_items(int unsigned n, int unsigned step_max, bit do_hold,
                              bit do_pause);
    int unsigned roll;
    int unsigned sub;
    int unsigned burst;
    logic [15:0] limit;
    evt_t        e;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (do_pause && i == n / 2) wait_all_results();
      if (do_hold && i == n / 3) begin
        hold_go = 1'b1;
        burst   = 60;
      end
      e.command           = cmd_t'($urandom_range(0, 3));
      e.start_request     = 1'($urandom_range(0, 1));
      e.follower_steering = 16'($urandom);
      e.front_right_cm    = 10'($urandom);
      e.side_right_cm     = 10'($urandom);
      e.distance_mm       = $urandom;
      roll = $urandom_range(0, 99);
      // Keep emitting events coming while the receiver is stalled.
      if (burst > 0) begin
        burst--;
        roll = sb.armed ? 10 : 0;
      end
      if (!sb.armed) begin
        if (roll < 85) begin
          e.command       = CMD_START_STOP;
          e.start_request = 1'b1;
        end
      end else if (roll < 55) begin
        e.command = CMD_DISTANCE;
        sub = $urandom_range(0, 99);
        if (sub < 20) begin
          // Land right on or just past the current mode's limit.
          case (sb.mode)
            MODE_LEFT:       limit = sb.cfg.left_swerve_dist_mm;
            MODE_RIGHT:      limit = sb.cfg.right_swerve_dist_mm;
            MODE_CHK_FR:     limit = CHK_FR_DIST_MM;
            MODE_CHK_R:      limit = CHK_R_DIST_MM;
            MODE_CHK_RR:     limit = CHK_RR_DIST_MM;
            MODE_BACK_RIGHT: limit = sb.cfg.right_back_dist_mm;
            MODE_BACK_LEFT:  limit = sb.cfg.left_back_dist_mm;
            default:         limit = '0;
          endcase
          odo = sb.mode_start + {16'd0, limit} + $urandom_range(0, 1);
        end else if (sub < 40) begin
          odo = odo + $urandom_range(0, 300);
        end else begin
          odo = odo + $urandom_range(0, step_max);
        end
        e.distance_mm = odo;
      end else if (roll < 70) begin
        e.command        = CMD_ULTRASONIC;
        e.front_right_cm = pick_range(e.front_right_cm);
        e.side_right_cm  = pick_range(e.side_right_cm);
      end else if (roll < 80) begin
        e.command = CMD_FOLLOWER;
      end else if (roll < 83) begin
        e.command       = CMD_START_STOP;
        e.start_request = 1'b0;
      end else if (roll < 85) begin
        e.command       = CMD_START_STOP;
        e.start_request = 1'b1;
      end
      push_event(e);
    end
  endtask

  localparam logic [31:0] BASE = 32'hFFFF_FF00;

  initial begin
    cfg_t c;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    ev.valid     = 1'b0;
    ev.command   = CMD_START_STOP;
    ev.start_request     = 1'b0;
    ev.follower_steering = '0;
    ev.front_right_cm    = '0;
    ev.side_right_cm     = '0;
    ev.distance_mm       = '0;
    steady       = 1'b0;
    hold_go      = 1'b0;
    odo          = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk through one full maneuver at reset settings, starting
    // just below the odometer wrap so that every mode sees wrapped distances.
    send(CMD_DISTANCE,   32'd1000);                 // not armed: ignored
    send(CMD_ULTRASONIC, {12'd0, 10'd0, 10'd1023}); // zero side range kept out
    send(CMD_FOLLOWER,   32'h0000_8000);
    send(CMD_START_STOP, 32'd1);
    send(CMD_DISTANCE,   BASE);                     // idle -> swerve left
    send(CMD_DISTANCE,   BASE + 700);               // exactly at limit: hold
    send(CMD_DISTANCE,   BASE + 1401);              // past limit -> right
    send(CMD_START_STOP, 32'd1);                    // start while running
    send(CMD_DISTANCE,   BASE + 2002);              // -> check front right
    send(CMD_ULTRASONIC, {12'd0, 10'd50, 10'd100});
    send(CMD_DISTANCE,   BASE + 3002);              // front not free: hold
    send(CMD_ULTRASONIC, {12'd0, 10'd0, 10'd101});
    send(CMD_FOLLOWER,   32'h0000_7FFF);
    send(CMD_DISTANCE,   BASE + 3203);              // -> check side right
    send(CMD_DISTANCE,   BASE + 4203);              // side not free: hold
    send(CMD_ULTRASONIC, {12'd0, 10'd101, 10'd0});
    send(CMD_DISTANCE,   BASE + 4504);              // -> check right rear
    send(CMD_ULTRASONIC, {12'd0, 10'd99, 10'd0});
    send(CMD_DISTANCE,   BASE + 4654);              // close car: restart
    send(CMD_DISTANCE,   BASE + 4854);              // at limit: restart again
    send(CMD_DISTANCE,   BASE + 5055);              // -> swerve right back
    send(CMD_DISTANCE,   BASE + 5656);              // -> swerve left back
    send(CMD_DISTANCE,   BASE + 6357);              // -> finish
    send(CMD_DISTANCE,   BASE + 6360);              // finish: flag set, idle
    send(CMD_DISTANCE,   32'hFFFF_FFFF);            // disarmed: ignored
    send(CMD_START_STOP, 32'd0);                    // stop keeps the flag
    odo = BASE + 6360;
    random_items(300, 800, 1'b0, 1'b0);
    finish_phase();

    // Zero thresholds, extreme speeds and steering; no idling on either side.
    c.left_swerve_dist_mm  = 16'd0;
    c.right_swerve_dist_mm = 16'd0;
    c.right_back_dist_mm   = 16'd0;
    c.left_back_dist_mm    = 16'd0;
    c.change_speed         = 16'sh8000;
    c.overtake_speed       = 16'sh7FFF;
    c.left_steer           = 15'd0;
    c.right_steer          = 15'h7FFF;
    load_settings(c);
    steady = 1'b1;
    random_items(300, 60, 1'b0, 1'b0);
    steady = 1'b0;
    finish_phase();

    // Largest thresholds, the other extremes; long receiver stall here.
    c.left_swerve_dist_mm  = 16'hFFFF;
    c.right_swerve_dist_mm = 16'hFFFF;
    c.right_back_dist_mm   = 16'hFFFF;
    c.left_back_dist_mm    = 16'hFFFF;
    c.change_speed         = 16'sh7FFF;
    c.overtake_speed       = 16'sh8000;
    c.left_steer           = 15'h7FFF;
    c.right_steer          = 15'd0;
    load_settings(c);
    random_items(300, 40000, 1'b1, 1'b0);
    finish_phase();

    // Two random settings; the first pauses the sender until drained.
    for (int p = 0; p < 2; p++) begin
      c.left_swerve_dist_mm  = 16'($urandom_range(0, 3000));
      c.right_swerve_dist_mm = 16'($urandom_range(0, 3000));
      c.right_back_dist_mm   = 16'($urandom_range(0, 3000));
      c.left_back_dist_mm    = 16'($urandom_range(0, 3000));
      c.change_speed         = 16'($urandom);
      c.overtake_speed       = 16'($urandom);
      c.left_steer           = 15'($urandom);
      c.right_steer          = 15'($urandom);
      load_settings(c);
      random_items(300, 3000, 1'b0, p == 0);
      finish_phase();
    end

    // Give any stray result time to show up before the verdict.
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
